// ===== hw/rtl/sas_pkg.sv =====
// Shared types and constants for the spike avalanche sizer.
// No dependencies; imported by every module of the block.
package sas_pkg;

    localparam int NEURON_COUNT  = 1024;
    localparam int IDX_BITS      = 10;
    localparam int SIZE_BITS     = 11;
    localparam int EPOCH_BITS    = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [EPOCH_BITS-1:0] epoch_t;

    localparam epoch_t EPOCH_NONE  = '0;
    localparam epoch_t EPOCH_FIRST = EPOCH_BITS'(1);
    localparam epoch_t EPOCH_MAX   = '1;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        epoch_t data;
    } tag_wr_t;

    typedef struct packed {
        size_t size;
        logic  run_final;
    } result_t;

endpackage

// ===== hw/rtl/sas_tag_ram.sv =====
// Avalanche tag memory: one epoch tag per neuron, one write and one read port.
// Read data registered. Depends on sas_pkg.
module sas_tag_ram import sas_pkg::*; (
    input  logic    aclk,
    input  tag_wr_t wr,
    input  logic    rd_en,
    input  idx_t    rd_addr,
    output epoch_t  rd_data
);

    epoch_t mem [0:NEURON_COUNT-1];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/sas_result_fifo.sv =====
// Result queue: takes up to two result beats a cycle, hands out one.
// Depends on sas_pkg.
module sas_result_fifo import sas_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [1:0]               push_cnt,
    input  result_t                  push0,
    input  result_t                  push1,
    input  logic                     pop,
    output logic                     out_valid,
    output result_t                  out_data,
    output logic [FIFO_CNT_BITS-1:0] used
);

    result_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] head_reg, head_next;
    logic [FIFO_PTR_BITS-1:0] tail_reg, tail_next;
    logic [FIFO_PTR_BITS-1:0] tail_inc;
    logic [FIFO_CNT_BITS-1:0] used_reg, used_next;

    assign tail_inc  = tail_reg + FIFO_PTR_BITS'(1);
    assign out_valid = (used_reg != '0);
    assign out_data  = slot_reg[head_reg];
    assign used      = used_reg;

    always_comb begin
        head_next = pop ? head_reg + FIFO_PTR_BITS'(1) : head_reg;
        tail_next = tail_reg + FIFO_PTR_BITS'(push_cnt);
        used_next = used_reg + FIFO_CNT_BITS'(push_cnt) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            slot_reg[tail_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            slot_reg[tail_inc] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            used_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            used_reg <= used_next;
        end
    end

endmodule

// ===== hw/rtl/spike_avalanche_sizer.sv =====
// Spike avalanche sizer: distinct-neuron count per avalanche of a spike stream.
// A result beat passes the second-stage registers and the result queue to m_valid.
// Throughput: one input beat per cycle when ready, bound by tag read-modify-write.
// Reset (aresetn low, synchronous) clears control, then all 1024 tags are swept
// with s_ready low; a like sweep repeats once every 65535 avalanche starts.
// Depends on sas_pkg, sas_tag_ram, sas_result_fifo.
module spike_avalanche_sizer import sas_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_event_time,
    input  logic [9:0]  s_neuron_index,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_avalanche_size,
    output logic        m_run_final
);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic                 state_reg, state_next;
    idx_t                 sweep_addr_reg, sweep_addr_next;
    logic                 keep_valid_reg, keep_valid_next;
    idx_t                 keep_idx_reg, keep_idx_next;
    logic [TIME_BITS-1:0] prior_time_reg, prior_time_next;
    logic                 prior_valid_reg, prior_valid_next;
    epoch_t               epoch_reg, epoch_next;
    size_t                count_reg, count_next;

    logic                 s1_valid_reg;
    idx_t                 s1_idx_reg;
    epoch_t               s1_epoch_reg;
    logic                 s1_cont_reg;
    logic                 s1_close_reg;
    logic                 s1_last_reg;
    logic                 s1_nowrite_reg;

    tag_wr_t              mem_wr;
    tag_wr_t              fwd_reg;
    epoch_t               rd_data;

    logic                 in_fire;
    logic [TIME_BITS-1:0] t_cur, time_inc;
    logic                 cont, wrap;
    epoch_t               epoch_new;

    epoch_t               tag_seen;
    logic                 already;
    size_t                count_add;
    logic                 close_emit;
    logic [1:0]           push_cnt;
    result_t              push0, push1;
    result_t              out_data;
    logic [FIFO_CNT_BITS-1:0] fifo_used;
    logic [FIFO_CNT_BITS:0]   fill_ahead;

    // accept side
    assign in_fire   = s_valid && s_ready;
    assign t_cur     = TIME_BITS'(s_event_time);
    assign time_inc  = prior_time_reg + TIME_BITS'(1);
    assign cont      = prior_valid_reg && ((t_cur == prior_time_reg) || (t_cur == time_inc));
    assign wrap      = !cont && (epoch_reg == EPOCH_MAX);
    assign epoch_new = cont ? epoch_reg : (wrap ? EPOCH_FIRST : epoch_reg + EPOCH_BITS'(1));

    assign fill_ahead = {1'b0, fifo_used} + (FIFO_CNT_BITS+1)'(push_cnt)
                      + (FIFO_CNT_BITS+1)'(2);
    assign s_ready    = (state_reg == ST_RUN)
                      && (fill_ahead <= (FIFO_CNT_BITS+1)'(FIFO_DEPTH));

    // second stage: membership check and count update
    always_comb begin
        tag_seen   = (fwd_reg.en && (fwd_reg.addr == s1_idx_reg)) ? fwd_reg.data : rd_data;
        already    = (tag_seen == s1_epoch_reg);
        count_add  = s1_cont_reg ? count_reg + SIZE_BITS'(!already) : SIZE_BITS'(1);
        close_emit = s1_valid_reg && s1_close_reg && (count_reg != '0);
        push_cnt   = s1_valid_reg ? 2'(close_emit) + 2'(s1_last_reg) : 2'd0;
        if (close_emit) begin
            push0.size      = count_reg;
            push0.run_final = !s1_last_reg;
        end else begin
            push0.size      = count_add;
            push0.run_final = 1'b1;
        end
        push1.size      = count_add;
        push1.run_final = 1'b1;
        count_next = count_reg;
        if (s1_valid_reg) begin
            count_next = s1_last_reg ? '0 : count_add;
        end
    end

    // tag writes: sweep has the port, else the second stage writes back unless it wrapped
    always_comb begin
        mem_wr = '{en: 1'b0, addr: s1_idx_reg, data: s1_epoch_reg};
        if (state_reg == ST_SWEEP) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = sweep_addr_reg;
            mem_wr.data = (keep_valid_reg && (sweep_addr_reg == keep_idx_reg))
                        ? EPOCH_FIRST : EPOCH_NONE;
        end else if (s1_valid_reg && !s1_nowrite_reg) begin
            mem_wr.en = 1'b1;
        end
    end

    always_comb begin
        state_next       = state_reg;
        sweep_addr_next  = sweep_addr_reg;
        keep_valid_next  = keep_valid_reg;
        keep_idx_next    = keep_idx_reg;
        prior_time_next  = prior_time_reg;
        prior_valid_next = prior_valid_reg;
        epoch_next       = epoch_reg;
        case (state_reg)
            ST_RUN: begin
                if (in_fire) begin
                    prior_time_next  = s_stream_end ? '0 : t_cur;
                    prior_valid_next = !s_stream_end;
                    epoch_next       = epoch_new;
                    if (wrap) begin
                        state_next      = ST_SWEEP;
                        sweep_addr_next = '0;
                        keep_valid_next = 1'b1;
                        keep_idx_next   = s_neuron_index;
                    end
                end
            end
            ST_SWEEP: begin
                sweep_addr_next = sweep_addr_reg + IDX_BITS'(1);
                if (sweep_addr_reg == idx_t'(NEURON_COUNT - 1)) begin
                    state_next      = ST_RUN;
                    keep_valid_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            sweep_addr_reg  <= '0;
            keep_valid_reg  <= 1'b0;
            prior_time_reg  <= '0;
            prior_valid_reg <= 1'b0;
            epoch_reg       <= EPOCH_FIRST;
            count_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_reg         <= '{en: 1'b0, addr: '0, data: EPOCH_NONE};
        end else begin
            state_reg       <= state_next;
            sweep_addr_reg  <= sweep_addr_next;
            keep_valid_reg  <= keep_valid_next;
            prior_time_reg  <= prior_time_next;
            prior_valid_reg <= prior_valid_next;
            epoch_reg       <= epoch_next;
            count_reg       <= count_next;
            s1_valid_reg    <= in_fire;
            fwd_reg         <= mem_wr;
        end
    end

    always_ff @(posedge aclk) begin
        keep_idx_reg <= keep_idx_next;
        if (in_fire) begin
            s1_idx_reg     <= s_neuron_index;
            s1_epoch_reg   <= epoch_new;
            s1_cont_reg    <= cont;
            s1_close_reg   <= !cont && prior_valid_reg;
            s1_last_reg    <= s_stream_end;
            s1_nowrite_reg <= wrap;
        end
    end

    sas_tag_ram u_tag_ram (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (in_fire),
        .rd_addr (s_neuron_index),
        .rd_data (rd_data)
    );

    sas_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .pop       (m_valid && m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .used      (fifo_used)
    );

    assign m_avalanche_size = out_data.size;
    assign m_run_final      = out_data.run_final;

    a_no_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_avalanche_size != '0))
        else $error("empty avalanche emitted");

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_used <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_epoch_live: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != EPOCH_NONE)
        else $error("epoch collides with cleared tag");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_stream_end) |=> (!prior_valid_reg ##1 (count_reg == '0)))
        else $error("stream end left avalanche state");

endmodule
